/* hw/rtl/sha1_message_digest_macros.svh */
// Assertion macros for the SHA-1 digest block.
// Included by the top level; needs nothing else.
`ifndef SHA1_MESSAGE_DIGEST_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SHA1_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define SHA1_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/sha1_pkg.sv */
// Shared types, constants and round functions for the SHA-1 digest block.
// No dependencies; imported by the top level.
`default_nettype none

package sha1_pkg;

  typedef logic [31:0] word_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_OUT
  } state_t;

  localparam int unsigned LEN_CNT_W_DEF = 61;
  localparam int unsigned NUM_ROUNDS    = 80;
  localparam int unsigned NUM_WORDS     = 5;
  localparam logic [5:0]  LEN_START     = 6'd56;
  localparam logic [5:0]  LAST_POS      = 6'd63;
  localparam logic [7:0]  PAD_MARK      = 8'h80;

  // Initial chaining value, h0 first
  localparam logic [0:4][31:0] IV = {
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  // Boolean function for round rnd
  function automatic word_t round_f(logic [6:0] rnd, word_t b, word_t c, word_t d);
    word_t f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  // Additive constant for round rnd
  function automatic word_t round_k(logic [6:0] rnd);
    word_t k;
    if (rnd < 7'd20) begin
      k = K0;
    end else if (rnd < 7'd40) begin
      k = K1;
    end else if (rnd < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/sha1_if.sv */
// Valid/ready channel interfaces for the SHA-1 digest block.
// Message byte channel in, digest word channel out; no dependencies.
`default_nettype none

interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, msg_byte, has_byte, end_of_message, input ready);
  modport sink   (input valid, msg_byte, has_byte, end_of_message, output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sha1_message_digest.sv */
// SHA-1 message digest over a byte stream.
// Uses sha1_pkg, the channel interfaces in sha1_if.sv and the assertion macros.
//
// Usage:
//   msg carries one transaction per message byte (has_byte) and/or an end mark
//   (end_of_message). A transaction with neither is taken and ignored.
//   digest returns five transactions per message, h0 first, word_index 0..4,
//   last_word set on h4.
// Timing:
//   A byte is taken whenever msg ready is high. The 64th byte of a block starts a
//   compression on the single round unit: the rounds, then a fold into the
//   chaining value, with msg ready low. At end of message the pad bytes, zeros
//   and length are shifted in one per cycle, followed by one or two compressions;
//   the five digest words follow, one per cycle when the receiver is ready.
// Reset:
//   rst (synchronous) restores the initial chaining value and clears the byte
//   count and controller. After h4 is taken the block returns to that state.
// Stalls:
//   A stalled digest word holds; msg stays not ready until all five are taken.
`default_nettype none

`include "sha1_message_digest_macros.svh"

module sha1_message_digest
  import sha1_pkg::*;
#(
  parameter int unsigned LENGTH_COUNTER_WIDTH = LEN_CNT_W_DEF
) (
  input  logic             clk,
  input  logic             rst,
  sha1_in_if.sink          msg,
  sha1_out_if.source       digest
);

  state_t state, state_next;

  word_t                           chain [NUM_WORDS];
  word_t                           va, vb, vc, vd, ve;
  logic [15:0][31:0]               win;
  logic [LENGTH_COUNTER_WIDTH-1:0] count;
  logic [5:0]                      ptr;
  logic [6:0]                      rnd;
  logic [2:0]                      idx;
  logic                            end_pend;
  logic                            padding;
  logic                            pad_first;
  logic                            pad_final;

  logic        accept;
  logic        out_done;
  logic        blk_full;
  logic        start_cmp;
  logic        shift_en;
  logic [7:0]  shift_byte;
  logic [63:0] len_bits;
  logic [7:0]  len_byte;
  word_t       w_new;
  word_t       t_sum;

  // Handshake
  assign accept   = msg.valid && msg.ready;
  assign out_done = digest.valid && digest.ready;
  assign blk_full = (ptr == LAST_POS);

  // Bit length, big-endian, byte selected by position within the last 8
  assign len_bits = 64'({count, 3'b000});
  assign len_byte = len_bits[{3'd7 - ptr[2:0], 3'b000} +: 8];

  // Byte entering the window
  always_comb begin
    shift_en   = 1'b0;
    shift_byte = msg.msg_byte;
    if (state == ST_IDLE) begin
      shift_en = accept && msg.has_byte;
    end else if (state == ST_PAD) begin
      shift_en = 1'b1;
      if (pad_first) begin
        shift_byte = PAD_MARK;
      end else if (pad_final && (ptr >= LEN_START)) begin
        shift_byte = len_byte;
      end else begin
        shift_byte = 8'h00;
      end
    end
  end

  // Next state and channel outputs
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (msg.has_byte && blk_full) begin
            state_next = ST_ROUND;
          end else if (msg.end_of_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (rnd == 7'(NUM_ROUNDS - 1)) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (padding) begin
          state_next = pad_final ? ST_OUT : ST_PAD;
        end else begin
          state_next = end_pend ? ST_PAD : ST_IDLE;
        end
      end
      ST_PAD: begin
        if (blk_full) begin
          state_next = ST_ROUND;
        end
      end
      ST_OUT: begin
        if (out_done && (idx == 3'(NUM_WORDS - 1))) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign start_cmp          = (state_next == ST_ROUND) && (state != ST_ROUND);
  assign msg.ready          = (state == ST_IDLE);
  assign digest.valid       = (state == ST_OUT);
  assign digest.digest_word = chain[idx];
  assign digest.word_index  = idx;
  assign digest.last_word   = (idx == 3'(NUM_WORDS - 1));

  // Round unit: schedule word and new a
  assign w_new = {win[13][30:0] ^ win[8][30:0] ^ win[2][30:0] ^ win[0][30:0],
                  win[13][31] ^ win[8][31] ^ win[2][31] ^ win[0][31]};
  assign t_sum = {va[26:0], va[31:27]} + round_f(rnd, vb, vc, vd) + ve
                 + round_k(rnd) + win[0];

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control counters, flags and chaining value
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ptr       <= '0;
      rnd       <= '0;
      idx       <= '0;
      end_pend  <= 1'b0;
      padding   <= 1'b0;
      pad_first <= 1'b0;
      pad_final <= 1'b0;
      for (int i = 0; i < NUM_WORDS; i++) begin
        chain[i] <= IV[i];
      end
    end else begin
      if (shift_en) begin
        ptr <= ptr + 6'd1;
      end
      if (start_cmp) begin
        rnd <= '0;
      end else if (state == ST_ROUND) begin
        rnd <= rnd + 7'd1;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            end_pend <= msg.end_of_message;
            if (msg.has_byte) begin
              count <= count + 1'b1;
            end
            if (!(msg.has_byte && blk_full) && msg.end_of_message) begin
              padding   <= 1'b1;
              pad_first <= 1'b1;
            end
          end
        end
        ST_FOLD: begin
          chain[0] <= chain[0] + va;
          chain[1] <= chain[1] + vb;
          chain[2] <= chain[2] + vc;
          chain[3] <= chain[3] + vd;
          chain[4] <= chain[4] + ve;
          if (!padding && end_pend) begin
            padding   <= 1'b1;
            pad_first <= 1'b1;
          end
          if (padding) begin
            pad_final <= 1'b1;
          end
        end
        ST_PAD: begin
          pad_first <= 1'b0;
          if (pad_first) begin
            pad_final <= (ptr < LEN_START);
          end
        end
        ST_OUT: begin
          if (out_done) begin
            if (idx == 3'(NUM_WORDS - 1)) begin
              idx       <= '0;
              count     <= '0;
              ptr       <= '0;
              end_pend  <= 1'b0;
              padding   <= 1'b0;
              pad_final <= 1'b0;
              for (int i = 0; i < NUM_WORDS; i++) begin
                chain[i] <= IV[i];
              end
            end else begin
              idx <= idx + 3'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Message window: byte shift while filling, word shift while compressing
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= {win[i][23:0], win[i+1][31:24]};
      end
      win[15] <= {win[15][23:0], shift_byte};
    end else if (state == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= w_new;
    end
  end

  // Working variables
  always_ff @(posedge clk) begin
    if (start_cmp) begin
      va <= chain[0];
      vb <= chain[1];
      vc <= chain[2];
      vd <= chain[3];
      ve <= chain[4];
    end else if (state == ST_ROUND) begin
      va <= t_sum;
      vb <= va;
      vc <= {vb[1:0], vb[31:2]};
      vd <= vc;
      ve <= vd;
    end
  end

  // Checks
  `SHA1_ASSERT_NOW(a_round_range, clk, rst, state == ST_ROUND, rnd < 7'(NUM_ROUNDS), "round counter past last round")
  `SHA1_ASSERT_NOW(a_ptr_tracks_count, clk, rst, !padding, ptr == count[5:0], "fill pointer out of step with byte count")
  `SHA1_ASSERT_NOW(a_no_overlap, clk, rst, msg.ready, !digest.valid, "input taken while digest pending")
  `SHA1_ASSERT_NEXT(a_clear_after_digest, clk, rst, out_done && digest.last_word, (count == '0) && (chain[0] == IV[0]), "state not restored after digest")

endmodule

`default_nettype wire
